// ===== sv/pets_pkg.sv =====
// Package for the per-event timing statistics unit: fixed field widths,
// request opcodes and the controller state type. No dependencies.
package pets_pkg;

	localparam int OP_BITS    = 1;
	localparam int IDX_BITS   = 5;
	localparam int IN_T_BITS  = 32;
	localparam int CNT_BITS   = 32;
	localparam int OUT_T_BITS = 32;
	localparam int TOT_BITS   = 48;

	localparam logic [OP_BITS-1:0] OP_RECORD = 1'b0;
	localparam logic [OP_BITS-1:0] OP_QUERY  = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} pets_state_t;

endpackage

// ===== sv/per_event_timing_statistics_unit.sv =====
// Per-event timing statistics unit: statistics table in synchronous memory,
// read-modify-write controller and a bit-serial divider for the mean.
// Depends on pets_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, op, event_index,      | request in
//          | sample_time                               |
//  out     | out_valid, out_ready, queried_event,      | result out
//          | exec_count, min_time, max_time,           |
//          | total_ticks, mean_time                    |
//
// A record request reads the memory at accept and writes the entry back in
// ST_LOOK. A query passes through ST_LOOK, then the divider when the entry
// holds at least one sample (one quotient bit per cycle), then ST_OUT.
// After reset a clearing pass writes zero to every entry, one per cycle, and
// in_ready stays low meanwhile.
// A finished query waits in the output register; the next request is taken
// while it waits, and only a further query result stalls on out_ready.
module per_event_timing_statistics_unit #(
	parameter int NUM_EVENTS = 32,
	parameter int TIME_BITS  = 32,
	parameter int SUM_BITS   = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pets_pkg::OP_BITS-1:0]      op,
	input  logic [pets_pkg::IDX_BITS-1:0]     event_index,
	input  logic [pets_pkg::IN_T_BITS-1:0]    sample_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pets_pkg::IDX_BITS-1:0]     queried_event,
	output logic [pets_pkg::CNT_BITS-1:0]     exec_count,
	output logic [pets_pkg::OUT_T_BITS-1:0]   min_time,
	output logic [pets_pkg::OUT_T_BITS-1:0]   max_time,
	output logic [pets_pkg::TOT_BITS-1:0]     total_ticks,
	output logic [pets_pkg::OUT_T_BITS-1:0]   mean_time
);
	import pets_pkg::*;

	localparam int AW = $clog2(NUM_EVENTS);
	// wide enough to hold both the index and NUM_EVENTS itself
	localparam int XW = ((AW > IDX_BITS) ? AW : IDX_BITS) + 1;
	localparam int SW = $clog2(SUM_BITS + 1);
	localparam int EW = CNT_BITS + SUM_BITS + 2 * TIME_BITS;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
	localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;

	pets_state_t state_q;

	// statistics memory: count, total, minimum and maximum of one entry per word
	logic [EW-1:0] stat_mem [NUM_EVENTS];

	logic [AW-1:0] clr_q;

	// request captured at accept
	logic [OP_BITS-1:0]   op_s1;
	logic [IDX_BITS-1:0]  idx_s1;
	logic [AW-1:0]        addr_s1;
	logic                 hit_s1;
	logic [TIME_BITS-1:0] t_s1;

	// registered read data
	logic [CNT_BITS-1:0]  rd_cnt_s2;
	logic [SUM_BITS-1:0]  rd_sum_s2;
	logic [TIME_BITS-1:0] rd_min_s2;
	logic [TIME_BITS-1:0] rd_max_s2;

	// query result being assembled
	logic [CNT_BITS-1:0]  q_cnt_q;
	logic [SUM_BITS-1:0]  q_sum_q;
	logic [TIME_BITS-1:0] q_min_q;
	logic [TIME_BITS-1:0] q_max_q;

	// divider
	logic [CNT_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [SW-1:0]       step_q;
	logic [CNT_BITS:0]   trial;
	logic                take;

	// output register
	logic                  out_valid_q;
	logic [IDX_BITS-1:0]   out_idx_q;
	logic [CNT_BITS-1:0]   out_cnt_q;
	logic [OUT_T_BITS-1:0] out_min_q;
	logic [OUT_T_BITS-1:0] out_max_q;
	logic [TOT_BITS-1:0]   out_tot_q;
	logic [OUT_T_BITS-1:0] out_mean_q;

	logic                 in_fire;
	logic [XW-1:0]        idx_x;
	logic                 in_table;
	logic [AW-1:0]        in_addr;
	logic [63:0]          t_x;
	logic [TIME_BITS-1:0] t_sat;

	logic                 mem_we;
	logic [AW-1:0]        wr_addr;
	logic [CNT_BITS-1:0]  wr_cnt;
	logic [SUM_BITS-1:0]  wr_sum;
	logic [TIME_BITS-1:0] wr_min;
	logic [TIME_BITS-1:0] wr_max;
	logic [SUM_BITS:0]    sum_wide;
	logic                 first;
	logic                 out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Decode the index; entries beyond the table are ignored by a record
	// and read back as all zero by a query.
	assign idx_x    = XW'(event_index);
	assign in_table = (idx_x < XW'(NUM_EVENTS));
	assign in_addr  = idx_x[AW-1:0];

	// Clamp a sample that does not fit the stored time width.
	assign t_x   = 64'(sample_time);
	assign t_sat = (t_x > 64'(TIME_MAX)) ? TIME_MAX : t_x[TIME_BITS-1:0];

	// Update of one entry from the registered read data.
	assign first    = (rd_cnt_s2 == '0);
	assign sum_wide = (SUM_BITS + 1)'(rd_sum_s2) + (SUM_BITS + 1)'(t_s1);

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = addr_s1;
		wr_cnt  = '0;
		wr_sum  = '0;
		wr_min  = '0;
		wr_max  = '0;
		if (state_q == ST_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == ST_LOOK && op_s1 == OP_RECORD && hit_s1) begin
			mem_we = 1'b1;
			wr_cnt = (rd_cnt_s2 == CNT_MAX) ? rd_cnt_s2 : rd_cnt_s2 + 1'b1;
			wr_sum = (sum_wide > (SUM_BITS + 1)'(SUM_MAX)) ? SUM_MAX
			                                                : sum_wide[SUM_BITS-1:0];
			wr_max = (t_s1 > rd_max_s2) ? t_s1 : rd_max_s2;
			wr_min = (first || t_s1 < rd_min_s2) ? t_s1 : rd_min_s2;
		end
	end

	// Memory: one write port, one registered read port. Only one request is
	// in flight, so a read never meets a pending write to the same entry.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stat_mem[wr_addr] <= {wr_cnt, wr_sum, wr_min, wr_max};
		end
		if (in_fire && in_table) begin
			{rd_cnt_s2, rd_sum_s2, rd_min_s2, rd_max_s2} <= stat_mem[in_addr];
		end
	end

	// Restoring divider step: one quotient bit per cycle.
	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign take  = (trial >= {1'b0, q_cnt_q});

	// Payload registers: capture the request, assemble and divide.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op;
			idx_s1  <= event_index;
			addr_s1 <= in_addr;
			hit_s1  <= in_table;
			t_s1    <= t_sat;
		end
		if (state_q == ST_LOOK) begin
			// hold the entry, or zeros for an index beyond the table
			q_cnt_q <= hit_s1 ? rd_cnt_s2 : '0;
			q_sum_q <= hit_s1 ? rd_sum_s2 : '0;
			q_min_q <= hit_s1 ? rd_min_s2 : '0;
			q_max_q <= hit_s1 ? rd_max_s2 : '0;
			rem_q   <= '0;
			quo_q   <= hit_s1 ? rd_sum_s2 : '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= take ? CNT_BITS'(trial - {1'b0, q_cnt_q}) : trial[CNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], take};
		end
		if (state_q == ST_OUT && out_free) begin
			out_idx_q  <= idx_s1;
			out_cnt_q  <= q_cnt_q;
			out_min_q  <= OUT_T_BITS'(q_min_q);
			out_max_q  <= OUT_T_BITS'(q_max_q);
			out_tot_q  <= TOT_BITS'(q_sum_q);
			// the sum itself is left in quo_q when the count is zero
			out_mean_q <= (q_cnt_q == '0) ? '0 : OUT_T_BITS'(quo_q);
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result when a query finishes; drop it once taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_EVENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					step_q <= '0;
					if (op_s1 == OP_RECORD) begin
						state_q <= ST_IDLE;
					end else if (hit_s1 && rd_cnt_s2 != '0) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(SUM_BITS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign queried_event = out_idx_q;
	assign exec_count    = out_cnt_q;
	assign min_time      = out_min_q;
	assign max_time      = out_max_q;
	assign total_ticks   = out_tot_q;
	assign mean_time     = out_mean_q;

endmodule
